// ===== hw/rtl/smm_pkg.sv =====
// Shared types and constants for the saturating matrix multiply block.
// Used by smm_cell and saturating_matrix_multiply; depends on nothing.
`default_nettype none

package smm_pkg;

    localparam int ELEM_W  = 62;
    localparam int HALF_W  = 31;
    localparam int COORD_W = 3;
    localparam int PHASE_W = 3;

    typedef logic [PHASE_W-1:0] t_phase;

    // cell beat phases
    localparam t_phase PH_OPS    = 3'd0;
    localparam t_phase PH_MUL_LL = 3'd1;
    localparam t_phase PH_MUL_HL = 3'd2;
    localparam t_phase PH_MUL_LH = 3'd3;
    localparam t_phase PH_MUL_HH = 3'd4;
    localparam t_phase PH_ACC_HH = 3'd5;
    localparam t_phase PH_TERM   = 3'd6;
    localparam t_phase PH_COMMIT = 3'd7;

    typedef enum logic {
        ST_LOAD,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [ELEM_W-1:0] left_element;
        logic [ELEM_W-1:0] right_element;
    } t_in_item;

    typedef struct packed {
        logic [ELEM_W-1:0]  product_element;
        logic [COORD_W-1:0] row_index;
        logic [COORD_W-1:0] column_index;
        logic               last_element;
    } t_out_item;

    typedef struct packed {
        t_phase phase;
        logic   commit;
    } t_cell_ctrl;

    typedef struct packed {
        logic               wr;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [ELEM_W-1:0]  left;
        logic [ELEM_W-1:0]  right;
    } t_load;

    typedef struct packed {
        logic               vld;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [ELEM_W-1:0]  acc;
    } t_link;

endpackage

`default_nettype wire

// ===== hw/rtl/smm_cell.sv =====
// One cell of the accumulation chain: holds column k of the left matrix and row k
// of the right matrix, adds the saturated term k to the passing partial sum.
// Depends on smm_pkg.
`default_nettype none

module smm_cell
    import smm_pkg::*;
#(
    parameter int MATRIX_DIM = 8,
    parameter int CELL_IDX   = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire t_load             i_load,
    input  wire logic [ELEM_W-1:0] i_limit,
    input  wire t_link             i_link,
    output t_link                  o_link
);

    localparam int IDX_W = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
    localparam logic [COORD_W-1:0] MY_IDX = COORD_W'(CELL_IDX);
    localparam int WIDE_W = ELEM_W + 32;

    logic [ELEM_W-1:0] r_col_a [MATRIX_DIM];
    logic [ELEM_W-1:0] r_row_b [MATRIX_DIM];

    logic [ELEM_W-1:0]   r_a;
    logic [ELEM_W-1:0]   r_b;
    logic [ELEM_W-1:0]   r_pp;
    logic [ELEM_W-1:0]   r_prod;
    logic                r_ovf;
    logic [ELEM_W-1:0]   r_term;
    t_link               r_link;

    logic [HALF_W-1:0]   mul_x;
    logic [HALF_W-1:0]   mul_y;
    logic [ELEM_W-1:0]   n_pp;
    logic [WIDE_W-1:0]   pp_shifted;
    logic [WIDE_W-1:0]   wide_sum;
    logic                sum_ovf;
    logic [ELEM_W:0]     acc_sum;
    logic [ELEM_W-1:0]   n_acc;

    always_ff @(posedge i_clk) begin
        if (i_load.wr) begin
            if (i_load.col == MY_IDX) begin
                r_col_a[i_load.row[IDX_W-1:0]] <= i_load.left;
            end
            if (i_load.row == MY_IDX) begin
                r_row_b[i_load.col[IDX_W-1:0]] <= i_load.right;
            end
        end
    end

    always_comb begin
        case (i_ctrl.phase)
            PH_MUL_HL: begin
                mul_x = r_a[ELEM_W-1:HALF_W];
                mul_y = r_b[HALF_W-1:0];
            end
            PH_MUL_LH: begin
                mul_x = r_a[HALF_W-1:0];
                mul_y = r_b[ELEM_W-1:HALF_W];
            end
            PH_MUL_HH: begin
                mul_x = r_a[ELEM_W-1:HALF_W];
                mul_y = r_b[ELEM_W-1:HALF_W];
            end
            default: begin
                mul_x = r_a[HALF_W-1:0];
                mul_y = r_b[HALF_W-1:0];
            end
        endcase
    end

    assign n_pp = ELEM_W'(mul_x) * ELEM_W'(mul_y);

    // cross terms sit 31 bits up; the low term is unshifted
    assign pp_shifted = (i_ctrl.phase == PH_MUL_LH || i_ctrl.phase == PH_MUL_HH)
                      ? {1'b0, r_pp, {HALF_W{1'b0}}}
                      : {{(WIDE_W-ELEM_W){1'b0}}, r_pp};
    assign wide_sum   = {{(WIDE_W-ELEM_W){1'b0}}, r_prod} + pp_shifted;
    assign sum_ovf    = |wide_sum[WIDE_W-1:ELEM_W];

    assign acc_sum = {1'b0, i_link.acc} + {1'b0, r_term};
    assign n_acc   = (acc_sum > {1'b0, i_limit}) ? i_limit : acc_sum[ELEM_W-1:0];

    always_ff @(posedge i_clk) begin
        case (i_ctrl.phase)
            PH_OPS: begin
                r_a    <= r_col_a[i_link.row[IDX_W-1:0]];
                r_b    <= r_row_b[i_link.col[IDX_W-1:0]];
                r_prod <= '0;
                r_ovf  <= 1'b0;
            end
            PH_MUL_LL: begin
                r_pp <= n_pp;
            end
            PH_MUL_HL, PH_MUL_LH, PH_MUL_HH: begin
                r_pp   <= n_pp;
                r_prod <= wide_sum[ELEM_W-1:0];
                r_ovf  <= r_ovf | sum_ovf;
            end
            PH_ACC_HH: begin
                r_ovf <= r_ovf | (|r_pp);
            end
            PH_TERM: begin
                r_term <= (r_ovf || r_prod > i_limit) ? i_limit : r_prod;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.vld <= 1'b0;
        end else if (i_ctrl.commit) begin
            r_link.vld <= i_link.vld;
        end
        if (i_ctrl.commit) begin
            r_link.row <= i_link.row;
            r_link.col <= i_link.col;
            r_link.acc <= n_acc;
        end
    end

    assign o_link = r_link;

endmodule

`default_nettype wire

// ===== hw/rtl/saturating_matrix_multiply.sv =====
// Saturating matrix multiply: loads two MATRIX_DIM x MATRIX_DIM matrices, one element
// pair per input transaction in row-major order (one transaction per cycle), then
// streams the product matrix in row-major order with the final element flagged.
// Product terms and running sums clamp at the limit register. The sums flow through
// a chain of MATRIX_DIM cells, one term per cell; each cell uses a single 31x31
// multiplier four times per term. While the product is computed no input is taken.
// Write the limit only while idle. Depends on smm_pkg and smm_cell.
`default_nettype none

module saturating_matrix_multiply
    import smm_pkg::*;
#(
    parameter int MATRIX_DIM = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [ELEM_W-1:0] i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out
);

    localparam int TOTAL_BEATS = MATRIX_DIM * MATRIX_DIM + MATRIX_DIM - 1;
    localparam int BEAT_W      = (TOTAL_BEATS > 1) ? $clog2(TOTAL_BEATS) : 1;
    localparam logic [COORD_W-1:0] LAST_COORD = COORD_W'(MATRIX_DIM - 1);
    localparam logic [BEAT_W-1:0]  LAST_BEAT  = BEAT_W'(TOTAL_BEATS - 1);

    t_state               r_state;
    t_state               n_state;
    t_phase               r_phase;
    logic [ELEM_W-1:0]    r_limit;
    logic [COORD_W-1:0]   r_ld_row;
    logic [COORD_W-1:0]   r_ld_col;
    logic [COORD_W-1:0]   r_inj_row;
    logic [COORD_W-1:0]   r_inj_col;
    logic                 r_inj_vld;
    logic [BEAT_W-1:0]    r_beat;
    logic                 r_pend;

    logic                 in_acc;
    logic                 ld_last;
    logic                 run;
    logic                 commit;
    t_cell_ctrl           cell_ctrl;
    t_load                load_bus;
    t_link                chain [MATRIX_DIM+1];

    assign in_acc  = i_in_valid && o_in_ready;
    assign ld_last = (r_ld_row == LAST_COORD) && (r_ld_col == LAST_COORD);
    assign commit  = run && (r_phase == PH_COMMIT) && (!r_pend || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_acc && ld_last) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (commit && r_beat == LAST_BEAT) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                run        = 1'b0;
            end
            ST_RUN: begin
                o_in_ready = 1'b0;
                run        = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
                run        = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_phase   <= PH_OPS;
            r_limit   <= '1;
            r_ld_row  <= '0;
            r_ld_col  <= '0;
            r_inj_row <= '0;
            r_inj_col <= '0;
            r_inj_vld <= 1'b0;
            r_beat    <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end

            if (in_acc) begin
                if (r_ld_col == LAST_COORD) begin
                    r_ld_col <= '0;
                    r_ld_row <= (r_ld_row == LAST_COORD) ? '0 : r_ld_row + 1'b1;
                end else begin
                    r_ld_col <= r_ld_col + 1'b1;
                end
            end

            if (in_acc && ld_last) begin
                r_inj_vld <= 1'b1;
                r_inj_row <= '0;
                r_inj_col <= '0;
                r_beat    <= '0;
            end else if (commit) begin
                r_beat <= r_beat + 1'b1;
                if (r_inj_col == LAST_COORD) begin
                    r_inj_col <= '0;
                    r_inj_row <= r_inj_row + 1'b1;
                    if (r_inj_row == LAST_COORD) begin
                        r_inj_vld <= 1'b0;
                    end
                end else begin
                    r_inj_col <= r_inj_col + 1'b1;
                end
            end

            if (run) begin
                if (r_phase != PH_COMMIT) begin
                    r_phase <= r_phase + 1'b1;
                end else if (commit) begin
                    r_phase <= PH_OPS;
                end
            end

            if (commit) begin
                r_pend <= chain[MATRIX_DIM-1].vld;
            end else if (i_out_ready) begin
                r_pend <= 1'b0;
            end
        end
    end

    assign cell_ctrl.phase = r_phase;
    assign cell_ctrl.commit = commit;

    assign load_bus.wr    = in_acc;
    assign load_bus.row   = r_ld_row;
    assign load_bus.col   = r_ld_col;
    assign load_bus.left  = i_in.left_element;
    assign load_bus.right = i_in.right_element;

    assign chain[0].vld = r_inj_vld;
    assign chain[0].row = r_inj_row;
    assign chain[0].col = r_inj_col;
    assign chain[0].acc = '0;

    for (genvar k = 0; k < MATRIX_DIM; k++) begin : g_cell
        smm_cell #(
            .MATRIX_DIM (MATRIX_DIM),
            .CELL_IDX   (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl),
            .i_load  (load_bus),
            .i_limit (r_limit),
            .i_link  (chain[k]),
            .o_link  (chain[k+1])
        );
    end

    assign o_out_valid           = r_pend;
    assign o_out.product_element = chain[MATRIX_DIM].acc;
    assign o_out.row_index       = chain[MATRIX_DIM].row;
    assign o_out.column_index    = chain[MATRIX_DIM].col;
    assign o_out.last_element    = (chain[MATRIX_DIM].row == LAST_COORD)
                                && (chain[MATRIX_DIM].col == LAST_COORD);

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD |-> r_phase == PH_OPS)
        else $error("phase counter running while loading");

    a_idle_no_inject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD |-> !r_inj_vld)
        else $error("injection still active after the run ended");

    a_load_done_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && ld_last |=> r_state == ST_RUN && r_inj_vld && r_beat == '0)
        else $error("full load did not start a run");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(commit))
        else $error("result appeared without a chain step");

endmodule

`default_nettype wire
